@@ src/pre_alignment_edit_filter_top_defines.svh @@
// assertion macros for the pre-alignment edit filter
// used by the port checker; needs clk and rst_n in the calling scope
`ifndef PRE_ALIGNMENT_EDIT_FILTER_TOP_DEFINES_SVH
`define PRE_ALIGNMENT_EDIT_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define PEF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pef port check failed");

// next-cycle implication
`define PEF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pef port check failed");

`endif

@@ src/pef_pkg.sv @@
// types and codes shared by the pre-alignment edit filter
// no dependencies
package pef_pkg;

  typedef struct packed {
    logic [7:0] read_base;
    logic [7:0] ref_base;
  } in_item_t;

  typedef struct packed {
    logic [8:0] score;
    logic [1:0] exit_path;
  } out_item_t;

  typedef enum logic [1:0] {
    PATH_PLAIN  = 2'd0,
    PATH_DEL    = 2'd1,
    PATH_INS    = 2'd2,
    PATH_WINDOW = 2'd3
  } path_t;

  typedef enum logic [1:0] {
    REG_SEQ_LENGTH  = 2'd0,
    REG_MAX_EDITS   = 2'd1,
    REG_WINDOW_SIZE = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD,
    ST_CHECK,
    ST_WFILL,
    ST_WLOAD,
    ST_WSCAN,
    ST_WUPD,
    ST_WSHIFT,
    ST_WDRAIN
  } state_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

endpackage

@@ src/pef_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module pef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/pre_alignment_edit_filter_top.sv @@
// pre-alignment edit filter, top level
// depends on pef_pkg and pef_ram
//
// usage: load one read base and one reference base per item with start while
// busy is low. the item at position seq_length-1 (clamped to 0..MAX_LEN-1)
// starts scoring and raises busy; other items give no result. when scoring
// ends one result (score, exit_path) shows on out_item with out_strobe high
// for one cycle; the receiver cannot stall, so an untaken result is dropped.
// scoring, L = length, e = edits, w = window: one plain mask pass plus up to
//   2e shift passes; each streams one base a cycle through the store and mask
//   memories, drains the write-back and checks
//   window search fills min(w,L) mask columns (with w > L this pass counts
//   the plain mask and reports), then per window position scans one mask
//   row a cycle, updates and shifts (no shift for the last), then drains
//   the chosen window
// the strobe is registered and rises in the cycle after the last scoring step.
// the mask memory holds one column of all rows per base and is updated by
// read-modify-write, so throughput is set by those passes.
// cfg writes are always ready and take effect at once.
// reset (synchronous, rst_n low) clears load position, state and strobe and sets config to its defaults.
module pre_alignment_edit_filter_top #(
  parameter int MAX_LEN    = 256,
  parameter int MAX_EDITS  = 8,
  parameter int MAX_WINDOW = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  pef_pkg::in_item_t                in_item,
  output logic                             out_strobe,
  output pef_pkg::out_item_t               out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pef_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW   = $clog2(MAX_LEN);
  localparam int CW   = (AW >= 9) ? AW + 1 : 9;
  localparam int ROWS = 2 * MAX_EDITS + 1;
  localparam int RW   = $clog2(ROWS);
  localparam int EW   = $clog2(MAX_EDITS + 1);
  localparam int WW   = $clog2(MAX_WINDOW + 1);

  pef_pkg::state_t state_r, state_nxt;
  pef_pkg::path_t  path_r, path_nxt;

  logic [8:0]  seq_length_r;
  logic [3:0]  max_edits_r;
  logic [3:0]  window_size_r;

  logic [CW-1:0] len_c;
  logic [EW-1:0] e_c;
  logic [WW-1:0] wl_c;

  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] q_r, q_nxt;
  logic [CW-1:0] g_r, g_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          skip_r, skip_nxt;
  logic [EW-1:0] i_r, i_nxt;
  logic [RW-1:0] r_r, r_nxt;
  logic [RW-1:0] brow_r, brow_nxt;
  logic [WW-1:0] best_r, best_nxt;

  logic          v2_r, v2_nxt;
  logic [AW-1:0] waddr2_r;
  logic          fill2_r;
  logic [RW-1:0] row2_r;

  logic [ROWS-1:0]       win_r [MAX_WINDOW];
  logic [ROWS-1:0]       win_nxt [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] ch_r, ch_nxt;

  logic                out_strobe_r, out_strobe_nxt;
  pef_pkg::out_item_t  out_item_r, out_item_nxt;

  logic          load_acc;
  logic [CW-1:0] ra_c;
  logic          fill_c;
  logic [RW-1:0] row_c;
  logic [CW-1:0] mraddr_c;
  logic [7:0]    rd_read, rd_ref;
  logic [ROWS-1:0] mask_rdata, mask_wdata;
  logic          bit2;
  logic [WW-1:0] z_c, magnet_c;
  logic [MAX_WINDOW-1:0] chn_c;
  logic          feed_en, feed_bit;

  assign load_acc  = start && !busy;
  assign busy      = (state_r != pef_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  always_comb begin
    if (seq_length_r == 9'd0) begin
      len_c = CW'(1);
    end else if (CW'(seq_length_r) > CW'(MAX_LEN)) begin
      len_c = CW'(MAX_LEN);
    end else begin
      len_c = CW'(seq_length_r);
    end
    if (int'(max_edits_r) > MAX_EDITS) begin
      e_c = EW'(MAX_EDITS);
    end else begin
      e_c = EW'(max_edits_r);
    end
    if (window_size_r == 4'd0) begin
      wl_c = WW'(1);
    end else if (int'(window_size_r) > MAX_WINDOW) begin
      wl_c = WW'(MAX_WINDOW);
    end else begin
      wl_c = WW'(window_size_r);
    end
  end

  // mask pass addressing
  always_comb begin
    case (path_r)
      pef_pkg::PATH_DEL: begin
        ra_c   = q_r - CW'(i_r);
        fill_c = q_r < CW'(i_r);
        row_c  = RW'(i_r);
      end
      pef_pkg::PATH_INS: begin
        ra_c   = q_r + CW'(i_r);
        fill_c = (q_r + CW'(i_r)) >= len_c;
        row_c  = RW'(e_c) + RW'(i_r);
      end
      default: begin
        ra_c   = q_r;
        fill_c = 1'b0;
        row_c  = '0;
      end
    endcase
  end

  always_comb begin
    case (state_r)
      pef_pkg::ST_WFILL: mraddr_c = g_r;
      pef_pkg::ST_WUPD:  mraddr_c = g_r + CW'(wl_c);
      default:           mraddr_c = q_r;
    endcase
  end

  pef_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_read_store (
    .clk   (clk),
    .we    (load_acc),
    .waddr (pos_r),
    .wdata (in_item.read_base),
    .raddr (ra_c[AW-1:0]),
    .rdata (rd_read)
  );

  pef_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ref_store (
    .clk   (clk),
    .we    (load_acc),
    .waddr (pos_r),
    .wdata (in_item.ref_base),
    .raddr (q_r[AW-1:0]),
    .rdata (rd_ref)
  );

  pef_ram #(.WIDTH(ROWS), .DEPTH(MAX_LEN)) u_mask_store (
    .clk   (clk),
    .we    (v2_r),
    .waddr (waddr2_r),
    .wdata (mask_wdata),
    .raddr (mraddr_c[AW-1:0]),
    .rdata (mask_rdata)
  );

  assign bit2 = fill2_r || (rd_read != rd_ref);

  always_comb begin
    mask_wdata = mask_rdata;
    mask_wdata[row2_r] = bit2;
  end

  // zero counts of the current row and of the chosen window
  always_comb begin
    z_c      = '0;
    magnet_c = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (k < int'(wl_c)) begin
        if (!win_r[k][r_r]) begin
          z_c = z_c + WW'(1);
        end
        if (!ch_r[k]) begin
          magnet_c = magnet_c + WW'(1);
        end
      end
    end
    chn_c = ch_r;
    if (best_r > magnet_c) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        if (k < int'(wl_c)) begin
          chn_c[k] = win_r[k][brow_r];
        end
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    path_nxt       = path_r;
    pos_nxt        = pos_r;
    q_nxt          = q_r;
    g_nxt          = g_r;
    cnt_nxt        = cnt_r;
    skip_nxt       = skip_r;
    i_nxt          = i_r;
    r_nxt          = r_r;
    brow_nxt       = brow_r;
    best_nxt       = best_r;
    v2_nxt         = 1'b0;
    win_nxt        = win_r;
    ch_nxt         = ch_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    feed_en        = 1'b0;
    feed_bit       = 1'b0;

    case (state_r)
      pef_pkg::ST_IDLE: begin
        if (load_acc) begin
          if (CW'(pos_r) + CW'(1) < len_c) begin
            pos_nxt = pos_r + AW'(1);
          end else begin
            pos_nxt   = '0;
            path_nxt  = pef_pkg::PATH_PLAIN;
            q_nxt     = '0;
            cnt_nxt   = '0;
            state_nxt = pef_pkg::ST_BUILD;
          end
        end
      end

      pef_pkg::ST_BUILD: begin
        if (q_r < len_c) begin
          v2_nxt = 1'b1;
          q_nxt  = q_r + CW'(1);
        end else if (!v2_r) begin
          state_nxt = pef_pkg::ST_CHECK;
        end
        if (v2_r && !fill2_r && bit2) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      pef_pkg::ST_CHECK: begin
        q_nxt = '0;
        if (cnt_r <= CW'(e_c) || (path_r == pef_pkg::PATH_PLAIN && e_c == '0)) begin
          out_strobe_nxt         = 1'b1;
          out_item_nxt.score     = 9'(len_c - cnt_r);
          out_item_nxt.exit_path = path_r;
          state_nxt              = pef_pkg::ST_IDLE;
        end else begin
          cnt_nxt   = '0;
          state_nxt = pef_pkg::ST_BUILD;
          case (path_r)
            pef_pkg::PATH_PLAIN: begin
              i_nxt    = EW'(1);
              path_nxt = pef_pkg::PATH_DEL;
            end
            pef_pkg::PATH_DEL: begin
              path_nxt = pef_pkg::PATH_INS;
            end
            default: begin
              if (i_r == e_c) begin
                g_nxt     = '0;
                skip_nxt  = 1'b0;
                path_nxt  = pef_pkg::PATH_WINDOW;
                state_nxt = pef_pkg::ST_WFILL;
              end else begin
                i_nxt    = i_r + EW'(1);
                path_nxt = pef_pkg::PATH_DEL;
              end
            end
          endcase
        end
      end

      pef_pkg::ST_WFILL: begin
        state_nxt = pef_pkg::ST_WLOAD;
      end

      pef_pkg::ST_WLOAD: begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
          if (k + 1 < int'(wl_c)) begin
            win_nxt[k] = win_r[k + 1];
            ch_nxt[k]  = ch_r[k + 1];
          end else if (k + 1 == int'(wl_c)) begin
            win_nxt[k] = mask_rdata;
            ch_nxt[k]  = mask_rdata[0];
          end
        end
        g_nxt = g_r + CW'(1);
        if (CW'(wl_c) > len_c) begin
          feed_en  = 1'b1;
          feed_bit = mask_rdata[0];
          if (g_r + CW'(1) == len_c) begin
            out_strobe_nxt         = 1'b1;
            out_item_nxt.score     = 9'(len_c - cnt_nxt);
            out_item_nxt.exit_path = pef_pkg::PATH_WINDOW;
            state_nxt              = pef_pkg::ST_IDLE;
          end else begin
            state_nxt = pef_pkg::ST_WFILL;
          end
        end else if (g_r + CW'(1) == CW'(wl_c)) begin
          g_nxt     = '0;
          r_nxt     = '0;
          best_nxt  = '0;
          brow_nxt  = '0;
          state_nxt = pef_pkg::ST_WSCAN;
        end else begin
          state_nxt = pef_pkg::ST_WFILL;
        end
      end

      pef_pkg::ST_WSCAN: begin
        if (z_c > best_r) begin
          best_nxt = z_c;
          brow_nxt = r_r;
        end else if (z_c == best_r && !win_r[0][r_r]) begin
          if (g_r != len_c - CW'(wl_c) || win_r[0][brow_r]) begin
            brow_nxt = r_r;
          end
        end
        if (r_r == RW'({e_c, 1'b0})) begin
          state_nxt = pef_pkg::ST_WUPD;
        end else begin
          r_nxt = r_r + RW'(1);
        end
      end

      pef_pkg::ST_WUPD: begin
        feed_en  = 1'b1;
        feed_bit = chn_c[0];
        for (int k = 0; k < MAX_WINDOW - 1; k++) begin
          ch_nxt[k] = chn_c[k + 1];
        end
        ch_nxt[MAX_WINDOW-1] = chn_c[MAX_WINDOW-1];
        if (g_r + CW'(wl_c) < len_c) begin
          state_nxt = pef_pkg::ST_WSHIFT;
        end else begin
          g_nxt     = g_r + CW'(1);
          state_nxt = pef_pkg::ST_WDRAIN;
        end
      end

      pef_pkg::ST_WSHIFT: begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
          if (k + 1 < int'(wl_c)) begin
            win_nxt[k] = win_r[k + 1];
          end else if (k + 1 == int'(wl_c)) begin
            win_nxt[k] = mask_rdata;
            ch_nxt[k]  = mask_rdata[0];
          end
        end
        g_nxt     = g_r + CW'(1);
        r_nxt     = '0;
        best_nxt  = '0;
        brow_nxt  = '0;
        state_nxt = pef_pkg::ST_WSCAN;
      end

      pef_pkg::ST_WDRAIN: begin
        if (g_r < len_c) begin
          feed_en  = 1'b1;
          feed_bit = ch_r[0];
          for (int k = 0; k < MAX_WINDOW - 1; k++) begin
            ch_nxt[k] = ch_r[k + 1];
          end
          g_nxt = g_r + CW'(1);
        end else begin
          out_strobe_nxt         = 1'b1;
          out_item_nxt.score     = 9'(len_c - cnt_r);
          out_item_nxt.exit_path = pef_pkg::PATH_WINDOW;
          state_nxt              = pef_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pef_pkg::ST_IDLE;
      end
    endcase

    // a one right after a counted one is not counted
    if (feed_en) begin
      if (skip_r) begin
        skip_nxt = 1'b0;
      end else if (feed_bit) begin
        cnt_nxt  = cnt_r + CW'(1);
        skip_nxt = 1'b1;
      end
    end
    if (state_r == pef_pkg::ST_WLOAD && feed_en && g_r + CW'(1) == len_c) begin
      out_item_nxt.score = 9'(len_c - cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pef_pkg::ST_IDLE;
      path_r        <= pef_pkg::PATH_PLAIN;
      pos_r         <= '0;
      v2_r          <= 1'b0;
      out_strobe_r  <= 1'b0;
      seq_length_r  <= 9'd100;
      max_edits_r   <= 4'd3;
      window_size_r <= 4'd4;
    end else begin
      state_r      <= state_nxt;
      path_r       <= path_nxt;
      pos_r        <= pos_nxt;
      v2_r         <= v2_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pef_pkg::REG_SEQ_LENGTH:  seq_length_r  <= cfg_data;
          pef_pkg::REG_MAX_EDITS:   max_edits_r   <= cfg_data[3:0];
          pef_pkg::REG_WINDOW_SIZE: window_size_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    g_r        <= g_nxt;
    cnt_r      <= cnt_nxt;
    skip_r     <= skip_nxt;
    i_r        <= i_nxt;
    r_r        <= r_nxt;
    brow_r     <= brow_nxt;
    best_r     <= best_nxt;
    waddr2_r   <= q_r[AW-1:0];
    fill2_r    <= fill_c;
    row2_r     <= row_c;
    win_r      <= win_nxt;
    ch_r       <= ch_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

@@ src/pef_checker.sv @@
// port checker for the pre-alignment edit filter, bound to the top level
// depends on pre_alignment_edit_filter_top_defines.svh
`include "pre_alignment_edit_filter_top_defines.svh"

module pef_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  `PEF_ASSERT_NEXT(a_single_strobe, out_strobe, !out_strobe)
  `PEF_ASSERT_NOW(a_strobe_after_busy, out_strobe, $past(busy) && !busy)
  `PEF_ASSERT_NOW(a_busy_from_item, $rose(busy), $past(start))

endmodule

bind pre_alignment_edit_filter_top pef_checker u_pef_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);
